### design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

### design/prba_pkg.sv
package prba_pkg;

    // default geometry
    localparam int unsigned PAGES_DEF   = 32'h1000;
    localparam int unsigned MAX_RUN_DEF = 256;

    // fixed field widths
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned START_W = 12;
    localparam int unsigned OLEN_W  = 13;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned FLD_W   = 2;

    // opcodes
    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    // page map field codes
    localparam logic [FLD_W-1:0] FLD_FREE = 2'b00;
    localparam logic [FLD_W-1:0] FLD_HEAD = 2'b01;
    localparam logic [FLD_W-1:0] FLD_CONT = 2'b11;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_ZEROLEN = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

    // one result item
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [OLEN_W-1:0]  length;
        logic [ST_W-1:0]    status;
    } result_t;

    // command item into the controller
    typedef struct packed {
        logic               opcode;
        logic [LEN_W-1:0]   req_length;
        logic [START_W-1:0] page_start;
    } cmd_t;

endpackage

### design/prba_ram.sv
module prba_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/prba_ctrl.sv
`include "assert_macros.svh"

module prba_ctrl #(
    parameter int unsigned PAGES   = prba_pkg::PAGES_DEF,
    parameter int unsigned MAX_RUN = prba_pkg::MAX_RUN_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  prba_pkg::cmd_t           cmd,
    output logic                     res_valid,
    input  logic                     res_ready,
    output prba_pkg::result_t        res,
    output logic                     mem_we,
    output logic [$clog2(PAGES)-1:0] mem_waddr,
    output logic [prba_pkg::FLD_W-1:0] mem_wdata,
    output logic [$clog2(PAGES)-1:0] mem_raddr,
    input  logic [prba_pkg::FLD_W-1:0] mem_rdata
);
    import prba_pkg::*;

    localparam int unsigned AW = $clog2(PAGES);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [2:0] {CLEAR, IDLE, SCAN, MARK, FREE, DONE} state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              dv_reg, dv_next;
    logic [AW-1:0]     daddr_reg, daddr_next;
    logic [LEN_W-1:0]  run_reg, run_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [CW-1:0]     count_reg, count_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              at_last;
    logic [LEN_W-1:0]  run_inc;
    logic [AW-1:0]     s_calc;

    assign accept    = cmd_valid && (state_reg == IDLE);
    assign cmd_ready = (state_reg == IDLE);
    assign res_valid = (state_reg == DONE);
    assign res       = res_reg;
    assign mem_raddr = idx_reg[AW-1:0];
    assign at_last   = (daddr_reg == AW'(PAGES - 1));
    assign run_inc   = mem_rdata[0] ? '0 : run_reg + LEN_W'(1);
    assign s_calc    = AW'({1'b0, daddr_reg} + CW'(1) - CW'(len_reg));

    // next state and memory port control
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dv_next    = 1'b0;
        daddr_next = daddr_reg;
        run_next   = run_reg;
        len_next   = len_reg;
        start_next = start_reg;
        count_next = count_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = FLD_FREE;
        unique case (state_reg)
            CLEAR: begin
                mem_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg[AW-1:0] == AW'(PAGES - 1)) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (accept) begin
                    if (cmd.opcode == OPC_ALLOC) begin
                        len_next = cmd.req_length;
                        if (cmd.req_length == '0) begin
                            res_next   = '{start: '0, length: '0, status: ST_ZEROLEN};
                            state_next = DONE;
                        end else if (32'(cmd.req_length) > 32'(MAX_RUN) ||
                                     32'(cmd.req_length) > 32'(PAGES)) begin
                            res_next   = '{start: '0, length: '0, status: ST_NOSPACE};
                            state_next = DONE;
                        end else begin
                            idx_next   = '0;
                            run_next   = '0;
                            state_next = SCAN;
                        end
                    end else begin
                        if (32'(cmd.page_start) >= 32'(PAGES)) begin
                            res_next   = '{start: cmd.page_start, length: '0,
                                           status: ST_RANGE};
                            state_next = DONE;
                        end else begin
                            // start page is always cleared and counted
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(cmd.page_start);
                            start_next = AW'(cmd.page_start);
                            count_next = CW'(1);
                            idx_next   = CW'(cmd.page_start) + CW'(1);
                            if (AW'(cmd.page_start) == AW'(PAGES - 1)) begin
                                res_next   = '{start: cmd.page_start, length: OLEN_W'(1),
                                               status: ST_OK};
                                state_next = DONE;
                            end else begin
                                state_next = FREE;
                            end
                        end
                    end
                end
            end
            SCAN: begin
                // issue next read while checking the previous one
                if (idx_reg < CW'(PAGES)) begin
                    idx_next = idx_reg + CW'(1);
                    dv_next  = 1'b1;
                end
                daddr_next = idx_reg[AW-1:0];
                if (dv_reg) begin
                    run_next = run_inc;
                    if (run_inc == len_reg) begin
                        start_next = s_calc;
                        idx_next   = CW'(s_calc);
                        daddr_next = daddr_reg;
                        state_next = MARK;
                    end else if (at_last) begin
                        res_next   = '{start: '0, length: '0, status: ST_NOSPACE};
                        state_next = DONE;
                    end
                end
            end
            MARK: begin
                // write head then continuation fields up to the run end
                mem_we    = 1'b1;
                mem_wdata = (idx_reg[AW-1:0] == start_reg) ? FLD_HEAD : FLD_CONT;
                idx_next  = idx_reg + CW'(1);
                if (idx_reg[AW-1:0] == daddr_reg) begin
                    res_next   = '{start: START_W'(start_reg), length: OLEN_W'(len_reg),
                                   status: ST_OK};
                    state_next = DONE;
                end
            end
            FREE: begin
                if (idx_reg < CW'(PAGES)) begin
                    idx_next = idx_reg + CW'(1);
                    dv_next  = 1'b1;
                end
                daddr_next = idx_reg[AW-1:0];
                if (dv_reg) begin
                    if (mem_rdata == FLD_HEAD || mem_rdata == FLD_FREE) begin
                        res_next   = '{start: START_W'(start_reg),
                                       length: OLEN_W'(count_reg), status: ST_OK};
                        state_next = DONE;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = daddr_reg;
                        count_next = count_reg + CW'(1);
                        if (at_last) begin
                            res_next   = '{start: START_W'(start_reg),
                                           length: OLEN_W'(count_reg + CW'(1)),
                                           status: ST_OK};
                            state_next = DONE;
                        end
                    end
                end
            end
            DONE: begin
                if (res_ready) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
            idx_reg   <= '0;
            dv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            dv_reg    <= dv_next;
        end
        daddr_reg <= daddr_next;
        run_reg   <= run_next;
        len_reg   <= len_next;
        start_reg <= start_next;
        count_reg <= count_next;
        res_reg   <= res_next;
    end

    `ASSERT_AT(a_scan_run_below_len, aclk, aresetn, (state_reg == SCAN) |-> (run_reg < len_reg), "run count reached request inside scan")
    `ASSERT_AT(a_mark_exit, aclk, aresetn, (state_reg == MARK) |=> (state_reg == MARK || state_reg == DONE), "mark left without result")
    `ASSERT_NEVER(a_free_count_zero, aclk, aresetn, (state_reg == FREE) && (count_reg == '0), "free walk lost start page")

endmodule

### design/page_run_bitmap_allocator_unit.sv
// channel   bus                  fields (lowest bit up)
// input     s_axis_t*            tuser: opcode; tdata: req_length, page_start
// result    m_axis_t*            tuser: status; tdata: out_start, out_length
//
// allocate: after the accept cycle the map is scanned from page 0, one map read per cycle,
//   then the run is marked, head first; a reject goes straight to the result
// free: the accept cycle clears the start page, then each following continuation page
//   is read and cleared until a head page, a free page or the map end is reached
// after reset the map is cleared one page per cycle, and no input is taken until it is done
// the result register lets the next item in while a result waits for m_axis_tready
`include "assert_macros.svh"

module page_run_bitmap_allocator_unit #(
    parameter int unsigned PAGES   = prba_pkg::PAGES_DEF,
    parameter int unsigned MAX_RUN = prba_pkg::MAX_RUN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_length[8:0], page_start[20:9], zero pad
    input  logic [0:0]  s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_start[11:0], out_length[24:12], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import prba_pkg::*;

    localparam int unsigned AW = $clog2(PAGES);

    cmd_t             cmd;
    result_t          res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [FLD_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [FLD_W-1:0] mem_rdata;
    logic             out_valid_reg;
    result_t          out_reg;

    // unpack the input transfer
    assign cmd.opcode     = s_axis_tuser[0];
    assign cmd.req_length = s_axis_tdata[8:0];
    assign cmd.page_start = s_axis_tdata[20:9];

    prba_ctrl #(.PAGES(PAGES), .MAX_RUN(MAX_RUN)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    prba_ram #(.WIDTH(FLD_W), .DEPTH(PAGES)) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.length, out_reg.start};
    assign m_axis_tuser  = out_reg.status;

    `ASSERT_AT(a_no_result_overwrite, aclk, aresetn, (out_valid_reg && !m_axis_tready) |=> out_valid_reg, "pending result dropped")

endmodule

### tb/sv/page_run_bitmap_allocator_unit_test.sv
module page_run_bitmap_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import prba_pkg::*;

    localparam int NPAGES = PAGES_DEF;
    localparam int MAXRUN = MAX_RUN_DEF;

    // page map mirror and expected results
    class alloc_scoreboard;
        logic [FLD_W-1:0] pmap [NPAGES];
        result_t pending_q[$];
        int errors;

        function void new_map();
            foreach (pmap[i]) pmap[i] = FLD_FREE;
            errors = 0;
        endfunction

        // predict the result of one accepted transfer
        function void note_cmd(logic opc, logic [LEN_W-1:0] len, logic [START_W-1:0] st);
            result_t r;
            int run;
            int s;
            int cnt;
            r = '0;
            if (opc == OPC_ALLOC) begin
                if (len == 0) begin
                    r.status = ST_ZEROLEN;
                end else if (len > MAXRUN) begin
                    r.status = ST_NOSPACE;
                end else begin
                    r.status = ST_NOSPACE;
                    run = 0;
                    for (int i = 0; i < NPAGES; i++) begin
                        run = pmap[i][0] ? 0 : run + 1;
                        if (run == len) begin
                            s = i + 1 - int'(len);
                            pmap[s] = FLD_HEAD;
                            for (int k = s + 1; k <= i; k++) pmap[k] = FLD_CONT;
                            r.start = START_W'(s);
                            r.length = OLEN_W'(len);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end else begin
                r.start = st;
                if (st >= NPAGES) begin
                    r.status = ST_RANGE;
                end else begin
                    pmap[st] = FLD_FREE;
                    cnt = 1;
                    for (int i = st + 1; i < NPAGES; i++) begin
                        if (pmap[i] == FLD_HEAD || pmap[i] == FLD_FREE) break;
                        pmap[i] = FLD_FREE;
                        cnt++;
                    end
                    r.length = OLEN_W'(cnt);
                    r.status = ST_OK;
                end
            end
            pending_q.push_back(r);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result start=%0d length=%0d status=%0d",
                         $realtime, got.start, got.length, got.status);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.start !== exp_r.start) begin
                $display("%0t start expected %0d actual %0d", $realtime, exp_r.start, got.start);
                errors++;
            end
            if (got.length !== exp_r.length) begin
                $display("%0t length expected %0d actual %0d", $realtime, exp_r.length,
                         got.length);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $display("%0t status expected %0d actual %0d", $realtime, exp_r.status,
                         got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    alloc_scoreboard board;
    longint cycle_count = 0;
    int gap_left = 0;

    page_run_bitmap_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 40000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver with its own stall pattern and result check
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result({m_axis_tdata[11:0], m_axis_tdata[24:12], m_axis_tuser});
        case (cycle_count[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // drive one transfer, holding valid across bursts
    task automatic send_cmd(logic opc, logic [LEN_W-1:0] len, logic [START_W-1:0] st);
        if (gap_left > 0) s_axis_tvalid <= 1'b0;
        while (gap_left > 0) begin
            @(posedge aclk);
            gap_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= opc;
        s_axis_tdata <= {3'b0, st, len};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_cmd(opc, len, st);
        // leave valid up; next call overwrites or a gap lowers it
        if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
    endtask

    // random length biased to small runs
    function automatic logic [LEN_W-1:0] pick_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return LEN_W'($urandom_range(257, 511));
        if (sel < 4) return LEN_W'($urandom_range(100, 256));
        return LEN_W'($urandom_range(1, 24));
    endfunction

    logic [START_W-1:0] heads[$];
    int idx;

    initial begin
        board = new;
        board.new_map();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes and special cases
        send_cmd(OPC_ALLOC, 0, 12'hfff);
        send_cmd(OPC_ALLOC, 257, 0);
        send_cmd(OPC_ALLOC, 511, 0);
        send_cmd(OPC_ALLOC, 1, 0);
        send_cmd(OPC_ALLOC, 256, 0);
        send_cmd(OPC_ALLOC, 3, 0);
        send_cmd(OPC_FREE, 0, 1);
        send_cmd(OPC_ALLOC, 1, 0);
        send_cmd(OPC_FREE, 9'h1ff, 100);
        send_cmd(OPC_FREE, 0, 0);
        send_cmd(OPC_FREE, 0, 5);
        send_cmd(OPC_FREE, 0, 12'hfff);
        // allocate long runs until one no longer fits, then fail
        for (int i = 0; i < 16; i++) send_cmd(OPC_ALLOC, 256, 0);
        send_cmd(OPC_ALLOC, 1, 0);
        send_cmd(OPC_FREE, 0, 12'd3840);
        send_cmd(OPC_FREE, 0, 12'd4095);
        send_cmd(OPC_ALLOC, 2, 0);
        for (int i = 0; i < 16; i++) send_cmd(OPC_FREE, 0, START_W'(i * 256));

        // random: alloc/free of known runs, plus noise frees
        for (int n = 0; n < 950; n++) begin
            int sel;
            sel = $urandom_range(0, 9);
            if (sel < 5 || heads.size() == 0) begin
                send_cmd(OPC_ALLOC, pick_len(), START_W'($urandom_range(0, 4095)));
                if (board.pending_q.size() > 0 &&
                    board.pending_q[$].status == ST_OK)
                    heads.push_back(board.pending_q[$].start);
            end else if (sel < 9) begin
                idx = $urandom_range(0, heads.size() - 1);
                send_cmd(OPC_FREE, LEN_W'($urandom_range(0, 511)), heads[idx]);
                heads.delete(idx);
            end else begin
                send_cmd(OPC_FREE, LEN_W'($urandom_range(0, 511)),
                         START_W'($urandom_range(0, 4095)));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending_q.size() > 0) @(posedge aclk);
        repeat (NPAGES + 300) @(posedge aclk);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
